[rtl/log_batch_coalescer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the log batch coalescer
// Short forms for same-cycle and next-cycle implications, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LOG_BATCH_COALESCER_ASSERT_SVH
`define LOG_BATCH_COALESCER_ASSERT_SVH

// Same-cycle implication
`define LBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// Log batch coalescer package
// Sizes, codes and record types used by the coalescer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   localparam int GROUPS           = 32;
   localparam int GRP_W            = 5;
   localparam int MSG_PREFIX_BYTES = 16;
   localparam int MSG_HEADER_BYTES = 168;
   localparam int MSG_FIXED_BYTES  = MSG_PREFIX_BYTES + MSG_HEADER_BYTES;

   localparam int LEN_W   = 16;
   localparam int SIZE_W  = 17;
   localparam int CNT_W   = 10;
   localparam int THR_W   = 6;
   localparam int TIME_W  = 32;
   localparam int TOUT_W  = 20;
   localparam int CSR_W   = 20;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   localparam logic [SIZE_W-1:0] BUFFER_BYTES_RST  = SIZE_W'(4096);
   localparam logic [TOUT_W-1:0] FLUSH_TIMEOUT_RST = TOUT_W'(1000);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FLUSH_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_FLUSH  = 2'd1,
      KIND_DROP   = 2'd2
   } kind_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_P_EV  = 6'b000010,
      ST_P_FIN = 6'b000100,
      ST_T_RD  = 6'b001000,
      ST_T_EV  = 6'b010000,
      ST_T_END = 6'b100000
   } state_type;

   // per-group batch record held in the state RAM
   typedef struct packed {
      logic              open;
      logic [CNT_W-1:0]  count;
      logic [SIZE_W-1:0] used;
      logic              armed;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      kind_type          kind;
      logic [GRP_W-1:0]  grp;
      logic [CNT_W-1:0]  seq;
      logic [LEN_W-1:0]  clen;
      logic [SIZE_W-1:0] mbytes;
      logic [CNT_W-1:0]  cnt;
      logic              last;
   } result_type;

endpackage

`default_nettype wire

[rtl/lbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/log_batch_coalescer.sv]
// ----------------------------------------------------------------------------
// Log batch coalescer
// Per-group batching of packet log messages with count, size and timeout
// flushes. Group records live in a RAM and are updated read-modify-write.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake          | Contents
//  req_*    | in  | tvalid/tready      | tuser: action; tdata: event fields
//  rsp_*    | out | tvalid/tready      | tuser: kind; tdata: result; tlast
//  csr_*    | in  | wr_en, no wait     | addr: register index; wdata: value
//
//  Steps: a packet event passes through ST_P_EV, and through ST_P_FIN as well
//  when it flushes its group first. A tick reads every group record in turn
//  through the one read port of the state RAM and checks it in the cycle after.
//  Reset: synchronous, clears all group records at once through valid bits.
//  Stalls: one output register; rsp_tready low only holds the sequencer when
//  a further result must be presented.
// ----------------------------------------------------------------------------
`default_nettype none
`include "log_batch_coalescer_assert.svh"

module log_batch_coalescer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: group[4:0], packet_len[20:5], copy_limit[36:21],
   //        count_threshold[42:37], zero[47:43]
   input  wire logic [lbc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: action (0 packet event, 1 tick)
   input  wire logic                                req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: out_group[4:0], seq[14:5], copied_len[30:15], msg_bytes[47:31],
   //        batch_count[57:48], zero[63:58]
   output logic      [lbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: kind
   output logic      [1:0]                          rsp_tuser,
   output logic                                     rsp_tlast,
   // configuration write port
   input  wire logic                                csr_wr_en,
   input  wire logic [lbc_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  wire logic [lbc_pkg::CSR_W-1:0]           csr_wdata
);

   // ---------------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------------
   lbc_pkg::state_type                 state_ff, state_in;
   logic [lbc_pkg::TIME_W-1:0]         time_now_ff, time_now_in;
   logic [lbc_pkg::SIZE_W-1:0]         buf_bytes_ff;
   logic [lbc_pkg::TOUT_W-1:0]         timeout_ff;
   logic [lbc_pkg::GROUPS-1:0]         valid_ff, valid_in;

   // registered packet event
   logic [lbc_pkg::GRP_W-1:0]          grp_ff, grp_in;
   logic [lbc_pkg::THR_W-1:0]          thr_ff, thr_in;
   logic [lbc_pkg::LEN_W-1:0]          clen_ff, clen_in;
   logic [lbc_pkg::SIZE_W-1:0]         size_ff, size_in;

   // tick scan
   logic [lbc_pkg::GRP_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic [lbc_pkg::GRP_W-1:0]          pend_grp_ff, pend_grp_in;
   logic [lbc_pkg::CNT_W-1:0]          pend_cnt_ff, pend_cnt_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   lbc_pkg::result_type                rsp_res_ff, rsp_res_in;
   logic                               out_free;
   logic                               push;
   lbc_pkg::result_type                push_res;

   // request field decode
   logic [lbc_pkg::GRP_W-1:0]          req_grp;
   logic [lbc_pkg::LEN_W-1:0]          req_plen;
   logic [lbc_pkg::LEN_W-1:0]          req_range;
   logic [lbc_pkg::THR_W-1:0]          req_thr;
   logic [lbc_pkg::LEN_W-1:0]          req_clen;
   logic                               req_xfer;

   // state RAM
   logic [lbc_pkg::GRP_W-1:0]          ram_rd_addr;
   logic [lbc_pkg::ENTRY_W-1:0]        ram_rd_data;
   logic                               ram_wr_en;
   logic [lbc_pkg::GRP_W-1:0]          rd_idx;
   lbc_pkg::entry_type                 cur_entry;
   lbc_pkg::entry_type                 base_entry;
   lbc_pkg::entry_type                 new_entry;

   // packet decision
   logic [lbc_pkg::SIZE_W-1:0]         room;
   logic                               need_flush;
   logic                               drop;
   logic [lbc_pkg::TIME_W-1:0]         tdiff;
   logic                               due;
   logic                               scan_done;

   // ---------------------------------------------------------------------
   // Request decode: work out copy length and aligned size on transfer
   // ---------------------------------------------------------------------
   assign req_grp   = req_tdata[4:0];
   assign req_plen  = req_tdata[20:5];
   assign req_range = req_tdata[36:21];
   assign req_thr   = req_tdata[42:37];
   assign req_xfer  = req_tvalid && req_tready;

   // a copy range of zero, or one longer than the packet, copies the whole packet
   assign req_clen = ((req_range == '0) || (req_range > req_plen)) ? req_plen : req_range;

   assign req_tready = (state_ff == lbc_pkg::ST_IDLE);

   // ---------------------------------------------------------------------
   // Group record store
   // ---------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            ram_rd_addr = req_grp;
         end
         lbc_pkg::ST_T_RD, lbc_pkg::ST_T_EV: begin
            ram_rd_addr = scan_idx_ff;
         end
         default: begin
            ram_rd_addr = grp_ff;
         end
      endcase
   end

   lbc_ram #(
      .WIDTH (lbc_pkg::ENTRY_W),
      .DEPTH (lbc_pkg::GROUPS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (grp_ff),
      .wr_data (new_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A record whose valid bit is clear reads as the reset record; the deadline
   // of such a record is never looked at because armed reads as zero.
   assign rd_idx    = (state_ff == lbc_pkg::ST_T_EV) ? scan_idx_ff : grp_ff;
   assign cur_entry = valid_ff[rd_idx] ? lbc_pkg::entry_type'(ram_rd_data) : '0;

   // After a flush in ST_P_EV the record starts afresh
   assign base_entry = (state_ff == lbc_pkg::ST_P_FIN) ? '0 : cur_entry;

   // ---------------------------------------------------------------------
   // Packet decision
   // ---------------------------------------------------------------------
   // room counts as zero when the buffer was shrunk below what is in use
   assign room = (base_entry.used >= buf_bytes_ff) ? '0 : (buf_bytes_ff - base_entry.used);

   assign need_flush = base_entry.open &&
                       ((base_entry.count >= lbc_pkg::CNT_W'(thr_ff)) || (size_ff > room));

   assign drop = (size_ff > buf_bytes_ff);

   always_comb begin
      new_entry       = base_entry;
      new_entry.open  = 1'b1;
      new_entry.count = base_entry.count + lbc_pkg::CNT_W'(1);
      new_entry.used  = base_entry.used + size_ff;
      new_entry.armed = 1'b1;
      if (!base_entry.armed) begin
         new_entry.deadline = time_now_ff + lbc_pkg::TIME_W'(timeout_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Tick check: due once time has reached the deadline (signed difference)
   // ---------------------------------------------------------------------
   assign tdiff     = time_now_ff - cur_entry.deadline;
   assign due       = cur_entry.armed && !tdiff[lbc_pkg::TIME_W-1];
   assign scan_done = (scan_idx_ff == lbc_pkg::GRP_W'(lbc_pkg::GROUPS - 1));

   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      time_now_in   = time_now_ff;
      valid_in      = valid_ff;
      grp_in        = grp_ff;
      thr_in        = thr_ff;
      clen_in       = clen_ff;
      size_in       = size_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_grp_in   = pend_grp_ff;
      pend_cnt_in   = pend_cnt_ff;
      ram_wr_en     = 1'b0;
      push          = 1'b0;
      push_res      = '0;

      case (state_ff)
         lbc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  // advance time and sweep every group
                  time_now_in   = time_now_ff + lbc_pkg::TIME_W'(1);
                  scan_idx_in   = '0;
                  pend_valid_in = 1'b0;
                  state_in      = lbc_pkg::ST_T_RD;
               end else begin
                  grp_in   = req_grp;
                  thr_in   = req_thr;
                  clen_in  = req_clen;
                  size_in  = (lbc_pkg::SIZE_W'(req_clen) +
                              lbc_pkg::SIZE_W'(lbc_pkg::MSG_FIXED_BYTES + 3)) &
                             ~lbc_pkg::SIZE_W'(3);
                  state_in = lbc_pkg::ST_P_EV;
               end
            end
         end

         lbc_pkg::ST_P_EV, lbc_pkg::ST_P_FIN: begin
            if (out_free) begin
               if ((state_ff == lbc_pkg::ST_P_EV) && need_flush) begin
                  // flush the open batch first; its record returns to reset
                  push          = 1'b1;
                  push_res.kind = lbc_pkg::KIND_FLUSH;
                  push_res.grp  = grp_ff;
                  push_res.cnt  = base_entry.count;
                  valid_in[grp_ff] = 1'b0;
                  state_in      = lbc_pkg::ST_P_FIN;
               end else begin
                  push          = 1'b1;
                  push_res.grp  = grp_ff;
                  push_res.clen = clen_ff;
                  push_res.mbytes = size_ff;
                  push_res.last = 1'b1;
                  if (drop) begin
                     push_res.kind = lbc_pkg::KIND_DROP;
                  end else begin
                     push_res.kind = lbc_pkg::KIND_APPEND;
                     push_res.seq  = base_entry.count;
                     ram_wr_en     = 1'b1;
                     valid_in[grp_ff] = 1'b1;
                  end
                  state_in = lbc_pkg::ST_IDLE;
               end
            end
         end

         lbc_pkg::ST_T_RD: begin
            state_in = lbc_pkg::ST_T_EV;
         end

         lbc_pkg::ST_T_EV: begin
            // hold one flush back so the final one can carry tlast
            if (!due || !pend_valid_ff || out_free) begin
               if (due) begin
                  if (pend_valid_ff) begin
                     push          = 1'b1;
                     push_res.kind = lbc_pkg::KIND_FLUSH;
                     push_res.grp  = pend_grp_ff;
                     push_res.cnt  = pend_cnt_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_grp_in   = scan_idx_ff;
                  pend_cnt_in   = cur_entry.count;
                  valid_in[scan_idx_ff] = 1'b0;
               end
               if (scan_done) begin
                  state_in = lbc_pkg::ST_T_END;
               end else begin
                  scan_idx_in = scan_idx_ff + lbc_pkg::GRP_W'(1);
                  state_in    = lbc_pkg::ST_T_RD;
               end
            end
         end

         lbc_pkg::ST_T_END: begin
            if (!pend_valid_ff) begin
               state_in = lbc_pkg::ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_res.kind = lbc_pkg::KIND_FLUSH;
               push_res.grp  = pend_grp_ff;
               push_res.cnt  = pend_cnt_ff;
               push_res.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = lbc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lbc_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: load on push, drop the valid on a completed transfer
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = push_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_res_ff.last;
   assign rsp_tdata  = {6'b0, rsp_res_ff.cnt, rsp_res_ff.mbytes, rsp_res_ff.clen,
                        rsp_res_ff.seq, rsp_res_ff.grp};

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbc_pkg::ST_IDLE;
         time_now_ff   <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_now_ff   <= time_now_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_bytes_ff <= lbc_pkg::BUFFER_BYTES_RST;
         timeout_ff   <= lbc_pkg::FLUSH_TIMEOUT_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            lbc_pkg::REG_BUFFER_BYTES: begin
               buf_bytes_ff <= csr_wdata[lbc_pkg::SIZE_W-1:0];
            end
            lbc_pkg::REG_FLUSH_TIMEOUT: begin
               timeout_ff <= csr_wdata[lbc_pkg::TOUT_W-1:0];
            end
            default: begin
               buf_bytes_ff <= buf_bytes_ff;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      thr_ff      <= thr_in;
      clen_ff     <= clen_in;
      size_ff     <= size_in;
      scan_idx_ff <= scan_idx_in;
      pend_grp_ff <= pend_grp_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_res_ff  <= rsp_res_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `LBC_ASSERT_NEXT(a_append_marks_valid, clock, reset, ram_wr_en,
      valid_ff[$past(grp_ff)], "appended group record not marked valid")

   `LBC_ASSERT_NEXT(a_flush_clears_group, clock, reset,
      (state_ff == lbc_pkg::ST_P_EV) && push && !push_res.last,
      !valid_ff[$past(grp_ff)] && (state_ff == lbc_pkg::ST_P_FIN),
      "packet flush did not clear its group record")

   `LBC_ASSERT_NOW(a_pending_in_scan, clock, reset, pend_valid_ff,
      (state_ff == lbc_pkg::ST_T_RD) || (state_ff == lbc_pkg::ST_T_EV) ||
      (state_ff == lbc_pkg::ST_T_END), "held flush outside a tick sweep")

   `LBC_ASSERT_NOW(a_last_closes_item, clock, reset, push && push_res.last,
      state_in == lbc_pkg::ST_IDLE, "last result pushed while the item continues")

endmodule

`default_nettype wire
